// File: hdl/assert_macros.svh
// Assertion helpers for the elevator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/zegc_pkg.sv
package zegc_pkg;

  localparam int Floors   = 32;
  localparam int Cars     = 3;
  localparam int Capacity = 15;

  localparam int FloorW = 6;
  localparam int FIdxW  = 5;
  localparam int CarW   = 2;
  localparam int LoadW  = 4;
  localparam int TimW   = 16;
  localparam int WaitW  = 8;

  localparam logic [2:0] CFG_ACTIVE = 3'd0;
  localparam logic [2:0] CFG_SPLIT1 = 3'd1;
  localparam logic [2:0] CFG_SPLIT2 = 3'd2;
  localparam logic [2:0] CFG_TOP    = 3'd3;
  localparam logic [2:0] CFG_MOVE   = 3'd4;
  localparam logic [2:0] CFG_OPEN   = 3'd5;
  localparam logic [2:0] CFG_CLOSE  = 3'd6;

  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [1:0] DOOR_CLOSED  = 2'd0;
  localparam logic [1:0] DOOR_OPENING = 2'd1;
  localparam logic [1:0] DOOR_OPEN    = 2'd2;
  localparam logic [1:0] DOOR_CLOSING = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [5:0] arrival_floor;
  } in_item_t;

  typedef struct packed {
    logic [1:0] car_index;
    logic [5:0] car_floor;
    logic [1:0] door_phase;
    logic       car_mode;
    logic [3:0] car_load;
    logic [3:0] delivered;
    logic       last_car;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  active_cars;
    logic [5:0]  first_split;
    logic [5:0]  second_split;
    logic [5:0]  top_floor;
    logic [15:0] move_ticks;
    logic [15:0] open_ticks;
    logic [15:0] close_ticks;
  } cfg_regs_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             arrive;     // apply arrival from held item
    logic             car_load;   // latch selected car into work regs
    logic             timers;     // door and move timer step
    logic             scan_init;  // start sector scan at sector top
    logic             scan_step;  // examine one floor, move down
    logic             decide;     // decision step
    logic             board;      // boarding / unloading step
    logic             car_store;  // write work regs back, emit result
    logic [CarW-1:0]  car;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } stat_t;

endpackage

// File: hdl/zoned_elevator_group_controller.sv
// Zoned down-peak dispatcher for up to three elevator cars.
// Input channel (in_valid/in_ready/in_data): an arrival item adds one
// waiting passenger at a floor and gives no result; a tick item steps
// every car in service and gives one status line per car, the last one
// flagged by last_car.
// Configuration: cfg_we with cfg_index and cfg_data writes one register;
// the user must do so while the block is idle; the block does not enforce it.
// An arrival passes through the ARRIVE state and back to IDLE. A tick
// steps each car through the LOAD, TIMER, SCAN, DECIDE, BOARD and STORE
// states. The scan examines one floor per cycle from the top of the sector
// down to the first floor where someone waits; when nobody waits it ends
// after stepping below the sector, and an empty sector ends on its first step.
// Results go through a one-entry output register. When the receiver
// stalls, the controller waits before writing the next status line and
// accepts no new item until the tick is fully delivered to that register.
// Reset (synchronous, rst_n low) clears all waiting counts, puts every
// car at floor one with doors closed and restores register defaults.
module zoned_elevator_group_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  zegc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output zegc_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import zegc_pkg::*;

  cfg_regs_t cfg_r;
  cmd_t      cmd;
  stat_t     stat;
  logic      in_accept;

  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_cars <= 2'd3;
      cfg_r.first_split <= 6'd10;
      cfg_r.second_split <= 6'd20;
      cfg_r.top_floor <= 6'd30;
      cfg_r.move_ticks <= 16'd20;
      cfg_r.open_ticks <= 16'd20;
      cfg_r.close_ticks <= 16'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE: cfg_r.active_cars <= cfg_data[1:0];
        CFG_SPLIT1: cfg_r.first_split <= cfg_data[5:0];
        CFG_SPLIT2: cfg_r.second_split <= cfg_data[5:0];
        CFG_TOP:    cfg_r.top_floor <= cfg_data[5:0];
        CFG_MOVE:   cfg_r.move_ticks <= cfg_data;
        CFG_OPEN:   cfg_r.open_ticks <= cfg_data;
        CFG_CLOSE:  cfg_r.close_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  zegc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .active_cars(cfg_r.active_cars),
    .out_busy(out_valid && !out_ready), .stat(stat), .cmd(cmd)
  );

  zegc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .in_accept(in_accept),
    .in_data(in_data), .cmd(cmd), .stat(stat), .out_ready(out_ready),
    .out_valid(out_valid), .out_data(out_data)
  );

`include "assert_macros.svh"

  `CHK_IMPL(a_store_free, cmd.car_store, !(out_valid && !out_ready),
    "status line written while output register is still full")
  `CHK_NEXT(a_store_valid, cmd.car_store, out_valid,
    "status line written but not presented")
  `CHK_IMPL(a_one_cmd, 1'b1,
    $countones({cmd.arrive, cmd.car_load, cmd.timers, cmd.decide, cmd.board,
                cmd.car_store}) <= 1, "more than one datapath step at once")

endmodule

// File: hdl/zegc_ctrl.sv
module zegc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  zegc_pkg::in_item_t in_data,
  input  logic [1:0]       active_cars,
  input  logic             out_busy,
  input  zegc_pkg::stat_t  stat,
  output zegc_pkg::cmd_t   cmd
);
  import zegc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ARRIVE, S_LOAD, S_TIMER, S_SCAN, S_DECIDE, S_BOARD, S_STORE
  } state_t;

  state_t          state_r, state_nxt;
  logic [CarW-1:0] car_r, car_nxt;
  logic [CarW-1:0] ncars;

  always_comb begin
    if (active_cars == 2'd0) ncars = 2'd1;
    else ncars = active_cars;
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    car_nxt = car_r;
    cmd = '0;
    cmd.car = car_r;
    cmd.last = (car_r + 2'd1 == ncars);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          car_nxt = '0;
          state_nxt = in_data.req_type ? S_LOAD : S_ARRIVE;
        end
      end
      S_ARRIVE: begin
        cmd.arrive = 1'b1;
        state_nxt = S_IDLE;
      end
      S_LOAD: begin
        cmd.car_load = 1'b1;
        state_nxt = S_TIMER;
      end
      S_TIMER: begin
        cmd.timers = 1'b1;
        cmd.scan_init = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt = S_BOARD;
      end
      S_BOARD: begin
        cmd.board = 1'b1;
        state_nxt = S_STORE;
      end
      S_STORE: begin
        // Hold until the output register is free for this line.
        if (!out_busy) begin
          cmd.car_store = 1'b1;
          if (cmd.last) state_nxt = S_IDLE;
          else begin
            car_nxt = car_r + 2'd1;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      car_r <= '0;
    end else begin
      state_r <= state_nxt;
      car_r <= car_nxt;
    end
  end

endmodule

// File: hdl/zegc_dp.sv
module zegc_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  zegc_pkg::cfg_regs_t cfg,
  input  logic              in_accept,
  input  zegc_pkg::in_item_t in_data,
  input  zegc_pkg::cmd_t    cmd,
  output zegc_pkg::stat_t   stat,
  input  logic              out_ready,
  output logic              out_valid,
  output zegc_pkg::out_item_t out_data
);
  import zegc_pkg::*;

  logic [WaitW-1:0]  wait_r   [Floors];
  logic [FloorW-1:0] pos_r    [Cars];
  logic [1:0]        dir_r    [Cars];
  logic              phase_r  [Cars];
  logic [1:0]        door_r   [Cars];
  logic [TimW-1:0]   dtim_r   [Cars];
  logic [TimW-1:0]   mtim_r   [Cars];
  logic [LoadW-1:0]  load_r   [Cars];

  in_item_t          held_r;
  logic [FloorW-1:0] wpos_r;
  logic [1:0]        wdir_r;
  logic              wphase_r;
  logic [1:0]        wdoor_r;
  logic [TimW-1:0]   wdtim_r;
  logic [TimW-1:0]   wmtim_r;
  logic [LoadW-1:0]  wload_r;
  logic [LoadW-1:0]  wdel_r;
  logic [FloorW:0]   scan_r;
  logic [FloorW:0]   target_r;
  logic [FloorW:0]   lo_r;
  logic [WaitW-1:0]  wcur_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [FloorW-1:0] top;
  logic [FloorW:0]   s_lo, s_hi;
  logic [FloorW-1:0] ncars;
  logic              scan_hit;
  logic [FIdxW-1:0]  pidx;

  always_comb begin
    if (cfg.top_floor < 6'd2) top = 6'd2;
    else if (cfg.top_floor > 6'(Floors)) top = 6'(Floors);
    else top = cfg.top_floor;
    ncars = (cfg.active_cars == 2'd0) ? 6'd1 : {4'd0, cfg.active_cars};
  end

  // Sector bounds for the selected car.
  always_comb begin
    logic [FloorW:0] e;
    s_lo = 7'd1;
    e = {1'b0, top};
    if (ncars >= 6'd2) begin
      if (cmd.car == 2'd0) e = {1'b0, cfg.first_split};
      else if (cmd.car == 2'd1) begin
        s_lo = {1'b0, cfg.first_split} + 7'd1;
        if (ncars == 6'd3) e = {1'b0, cfg.second_split};
      end else s_lo = {1'b0, cfg.second_split} + 7'd1;
    end
    if (e > {1'b0, top}) e = {1'b0, top};
    s_hi = e;
  end

  assign scan_hit = (scan_r >= lo_r) && (scan_r >= 7'd1) &&
                    (wait_r[5'(scan_r - 7'd1)] != '0);
  assign stat.scan_done = (scan_r < lo_r) || (scan_r < 7'd1) || scan_hit;
  assign pidx = 5'(wpos_r - 6'd1);

  always_ff @(posedge clk) begin
    logic [FloorW-1:0] p;
    logic [LoadW-1:0]  room, take;
    logic              act;
    logic [1:0]        dd;
    logic [TimW-1:0]   dt, mt;
    if (in_accept) held_r <= in_data;

    if (cmd.arrive) begin
      if (held_r.arrival_floor >= 6'd2 && held_r.arrival_floor <= top &&
          wait_r[5'(held_r.arrival_floor - 6'd1)] != 8'hFF)
        wait_r[5'(held_r.arrival_floor - 6'd1)] <=
          wait_r[5'(held_r.arrival_floor - 6'd1)] + 8'd1;
    end

    if (cmd.car_load) begin
      wpos_r <= pos_r[cmd.car];
      wdir_r <= dir_r[cmd.car];
      wphase_r <= phase_r[cmd.car];
      wdoor_r <= door_r[cmd.car];
      wdtim_r <= dtim_r[cmd.car];
      wmtim_r <= mtim_r[cmd.car];
      wload_r <= load_r[cmd.car];
      wdel_r <= '0;
    end

    if (cmd.timers) begin
      dd = wdoor_r;
      dt = wdtim_r;
      if (dd != DOOR_CLOSED) begin
        if (dt != '0) dt = dt - 16'd1;
        if (dt == '0) begin
          if (dd == DOOR_OPENING) dd = DOOR_OPEN;
          else if (dd == DOOR_CLOSING) dd = DOOR_CLOSED;
        end
      end
      wdoor_r <= dd;
      wdtim_r <= dt;
      mt = wmtim_r;
      if (mt != '0) begin
        mt = mt - 16'd1;
        if (mt == '0) begin
          p = wpos_r;
          if (wdir_r == DIR_UP) p = p + 6'd1;
          else if (wdir_r == DIR_DOWN && p != '0) p = p - 6'd1;
          if (p < 6'd1) p = 6'd1;
          if (p > top) p = top;
          wpos_r <= p;
        end
      end
      wmtim_r <= mt;
    end

    if (cmd.scan_init) begin
      scan_r <= s_hi;
      lo_r <= s_lo;
      target_r <= '0;
    end else if (cmd.scan_step) begin
      if (scan_hit) target_r <= scan_r;
      else if (!stat.scan_done) scan_r <= scan_r - 7'd1;
    end

    if (cmd.decide) begin
      if (wdoor_r == DOOR_CLOSED && wmtim_r == '0) begin
        if (!wphase_r) begin
          if (target_r != '0) begin
            if ({1'b0, wpos_r} == target_r) begin
              wphase_r <= 1'b1;
              wdir_r <= DIR_DOWN;
              wdoor_r <= DOOR_OPENING;
              wdtim_r <= cfg.open_ticks;
            end else begin
              wdir_r <= (target_r > {1'b0, wpos_r}) ? DIR_UP : DIR_DOWN;
              wmtim_r <= cfg.move_ticks;
            end
          end
        end else if (wpos_r == 6'd1) begin
          if (wload_r != '0) begin
            wdoor_r <= DOOR_OPENING;
            wdtim_r <= cfg.open_ticks;
          end else begin
            wphase_r <= 1'b0;
            wdir_r <= DIR_IDLE;
          end
        end else begin
          act = (wpos_r <= 6'(Floors)) && (wait_r[pidx] != '0) &&
                (wload_r < 4'(Capacity));
          if (act) begin
            wdoor_r <= DOOR_OPENING;
            wdtim_r <= cfg.open_ticks;
          end else wmtim_r <= cfg.move_ticks;
        end
      end
      wcur_r <= wait_r[pidx];
    end

    if (cmd.board && wdoor_r == DOOR_OPEN) begin
      if (wpos_r == 6'd1) begin
        wdel_r <= wload_r;
        wload_r <= '0;
      end else if (wpos_r >= 6'd1 && wpos_r <= 6'(Floors) &&
                   wload_r < 4'(Capacity)) begin
        room = 4'(Capacity) - wload_r;
        take = (wcur_r < {4'd0, room}) ? wcur_r[3:0] : room;
        wait_r[pidx] <= wcur_r - {4'd0, take};
        wload_r <= wload_r + take;
      end
      wdoor_r <= DOOR_CLOSING;
      wdtim_r <= cfg.close_ticks;
    end

    if (cmd.car_store) begin
      pos_r[cmd.car] <= wpos_r;
      dir_r[cmd.car] <= wdir_r;
      phase_r[cmd.car] <= wphase_r;
      door_r[cmd.car] <= wdoor_r;
      dtim_r[cmd.car] <= wdtim_r;
      mtim_r[cmd.car] <= wmtim_r;
      load_r[cmd.car] <= wload_r;
      out_r.car_index <= cmd.car;
      out_r.car_floor <= wpos_r;
      out_r.door_phase <= wdoor_r;
      out_r.car_mode <= wphase_r;
      out_r.car_load <= wload_r;
      out_r.delivered <= wdel_r;
      out_r.last_car <= cmd.last;
    end

    if (!rst_n) begin
      for (int i = 0; i < Floors; i++) wait_r[i] <= '0;
      for (int c = 0; c < Cars; c++) begin
        pos_r[c] <= 6'd1;
        dir_r[c] <= DIR_IDLE;
        phase_r[c] <= 1'b0;
        door_r[c] <= DOOR_CLOSED;
        dtim_r[c] <= '0;
        mtim_r[c] <= '0;
        load_r[c] <= '0;
      end
      out_valid_r <= 1'b0;
    end else if (cmd.car_store) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

// File: test/tb.sv
module tb;
  import zegc_pkg::*;

  localparam int IdleLimit = 6000;
  localparam int Drain     = 150;
  localparam logic [2:0] CfgNone = 3'd7;

  typedef struct {
    in_item_t item;
    bit       typed;  // expectations typed in: all cars parked at floor one
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  out_item_t status_q[$];
  int        failures = 0;
  int        quiet_cycles = 0;
  int        burst_left = 0;

  // Predictor state
  logic [7:0]  waits[Floors];
  logic [5:0]  pos[Cars];
  logic [1:0]  dir[Cars];
  logic        phase[Cars];
  logic [1:0]  door[Cars];
  logic [15:0] dtim[Cars];
  logic [15:0] mtim[Cars];
  logic [3:0]  load[Cars];
  logic [1:0]  r_cars;
  logic [5:0]  r_split1, r_split2, r_top;
  logic [15:0] r_move, r_open, r_close;

  zoned_elevator_group_controller dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int served_top();
    if (r_top < 2) return 2;
    if (r_top > Floors) return Floors;
    return int'(r_top);
  endfunction

  function automatic int waiting_at(int f);
    if (f < 1 || f > Floors) return 0;
    return int'(waits[f-1]);
  endfunction

  task automatic reset_predictor();
    for (int i = 0; i < Floors; i++) waits[i] = '0;
    for (int c = 0; c < Cars; c++) begin
      pos[c] = 6'd1; dir[c] = DIR_IDLE; phase[c] = 1'b0; door[c] = DOOR_CLOSED;
      dtim[c] = '0; mtim[c] = '0; load[c] = '0;
    end
    r_cars = 2'd3; r_split1 = 6'd10; r_split2 = 6'd20; r_top = 6'd30;
    r_move = 16'd20; r_open = 16'd20; r_close = 16'd20;
  endtask

  task automatic open_car(int c);
    door[c] = DOOR_OPENING;
    dtim[c] = r_open;
  endtask

  task automatic step_car(input int c, input int n, output int delivered);
    int top, p, lo, hi, target, room, w, take;
    top = served_top();
    delivered = 0;
    if (door[c] != DOOR_CLOSED) begin
      if (dtim[c] > 0) dtim[c]--;
      if (dtim[c] == 0) begin
        if (door[c] == DOOR_OPENING) door[c] = DOOR_OPEN;
        else if (door[c] == DOOR_CLOSING) door[c] = DOOR_CLOSED;
      end
    end
    if (mtim[c] > 0) begin
      mtim[c]--;
      if (mtim[c] == 0) begin
        p = int'(pos[c]);
        if (dir[c] == DIR_UP) p++;
        else if (dir[c] == DIR_DOWN && p > 0) p--;
        if (p < 1) p = 1;
        if (p > top) p = top;
        pos[c] = 6'(p);
      end
    end
    if (door[c] == DOOR_CLOSED && mtim[c] == 0) begin
      p = int'(pos[c]);
      if (!phase[c]) begin
        lo = 1; hi = top; target = 0;
        if (n >= 2) begin
          if (c == 0) hi = int'(r_split1);
          else if (c == 1) begin
            lo = r_split1 + 1;
            hi = (n == 3) ? int'(r_split2) : top;
          end else lo = r_split2 + 1;
        end
        if (hi > top) hi = top;
        for (int f = hi; f >= lo && f >= 1; f--) begin
          if (waiting_at(f) != 0) begin
            target = f;
            break;
          end
        end
        if (target != 0) begin
          if (p == target) begin
            phase[c] = 1'b1;
            dir[c] = DIR_DOWN;
            open_car(c);
          end else begin
            dir[c] = (target > p) ? DIR_UP : DIR_DOWN;
            mtim[c] = r_move;
          end
        end
      end else if (p == 1) begin
        if (load[c] != 0) open_car(c);
        else begin
          phase[c] = 1'b0;
          dir[c] = DIR_IDLE;
        end
      end else begin
        if (waiting_at(p) != 0 && load[c] < Capacity) open_car(c);
        else mtim[c] = r_move;
      end
    end
    if (door[c] == DOOR_OPEN) begin
      p = int'(pos[c]);
      if (p == 1) begin
        delivered = int'(load[c]);
        load[c] = '0;
      end else if (p >= 1 && p <= Floors && load[c] < Capacity) begin
        room = Capacity - int'(load[c]);
        w = int'(waits[p-1]);
        take = (w < room) ? w : room;
        waits[p-1] = 8'(w - take);
        load[c] = 4'(int'(load[c]) + take);
      end
      door[c] = DOOR_CLOSING;
      dtim[c] = r_close;
    end
  endtask

  // Works out the status lines that one accepted item gives.
  task automatic predict_item(in_item_t it);
    int n, d, f;
    out_item_t s;
    if (!it.req_type) begin
      f = int'(it.arrival_floor);
      if (f >= 2 && f <= served_top() && waits[f-1] < 255) waits[f-1]++;
      return;
    end
    n = (r_cars < 1) ? 1 : ((r_cars > Cars) ? Cars : int'(r_cars));
    for (int c = 0; c < n; c++) begin
      step_car(c, n, d);
      s.car_index  = 2'(c);
      s.car_floor  = pos[c];
      s.door_phase = door[c];
      s.car_mode   = phase[c];
      s.car_load   = load[c];
      s.delivered  = 4'(d);
      s.last_car   = (c + 1 == n);
      status_q = {status_q, s};
    end
  endtask

  task automatic send(in_item_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Accepted transfers feed the predictor in sampling order.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_item(in_data);
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_ACTIVE: r_cars   = val[1:0];
      CFG_SPLIT1: r_split1 = val[5:0];
      CFG_SPLIT2: r_split2 = val[5:0];
      CFG_TOP:    r_top    = val[5:0];
      CFG_MOVE:   r_move   = val;
      CFG_OPEN:   r_open   = val;
      CFG_CLOSE:  r_close  = val;
      default: ;
    endcase
  endtask

  task automatic configure(int cars, int s1, int s2, int top, int mv, int op, int cl);
    wait_drained();
    write_reg(CFG_ACTIVE, 16'(cars));
    write_reg(CFG_SPLIT1, 16'(s1));
    write_reg(CFG_SPLIT2, 16'(s2));
    write_reg(CFG_TOP, 16'(top));
    write_reg(CFG_MOVE, 16'(mv));
    write_reg(CFG_OPEN, 16'(op));
    write_reg(CFG_CLOSE, 16'(cl));
    // An index past the register list must change nothing.
    write_reg(CfgNone, 16'hFFFF);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int count);
    in_item_t it;
    int top;
    top = served_top();
    for (int i = 0; i < count; i++) begin
      it.req_type = ($urandom_range(0, 99) < 40);
      if ($urandom_range(0, 9) == 0) it.arrival_floor = 6'($urandom_range(0, 63));
      else it.arrival_floor = 6'($urandom_range(2, top));
      send(it);
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        $error("status line with nothing expected: %p", out_data);
        failures++;
      end else begin
        want = status_q.pop_front();
        check_field("car_index", int'(want.car_index), int'(out_data.car_index));
        check_field("car_floor", int'(want.car_floor), int'(out_data.car_floor));
        check_field("door_phase", int'(want.door_phase), int'(out_data.door_phase));
        check_field("car_mode", int'(want.car_mode), int'(out_data.car_mode));
        check_field("car_load", int'(want.car_load), int'(out_data.car_load));
        check_field("delivered", int'(want.delivered), int'(out_data.delivered));
        check_field("last_car", int'(want.last_car), int'(out_data.last_car));
      end
    end
  end

  // Receiver: segments of no stall, random stall and a fixed stall pattern.
  int rx_cycle = 0;
  int rx_mode = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (rx_cycle % 5 >= 2);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  dir_row_t rows[$];

  function automatic dir_row_t row(bit tick, int floor, bit typed = 0);
    dir_row_t r;
    r.item.req_type = tick;
    r.item.arrival_floor = 6'(floor);
    r.typed = typed;
    return r;
  endfunction

  initial begin
    out_item_t parked;
    reset_predictor();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    rows = {row(1, 0, 1), row(0, 1), row(0, 0), row(0, 63), row(0, 31),
            row(0, 32), row(1, 0, 1), row(0, 2), row(0, 30), row(0, 15),
            row(0, 25), row(0, 5), row(0, 30), row(1, 63), row(1, 0),
            row(1, 0), row(0, 10), row(0, 11), row(0, 20), row(0, 21),
            row(1, 0), row(1, 0), row(1, 0)};
    foreach (rows[i]) begin
      // A typed row starts with nothing else in flight.
      if (rows[i].typed) wait_drained();
      send(rows[i].item);
      if (rows[i].typed) begin
        in_valid <= 1'b0;
        burst_left = 0;
        // Nobody waits in service range yet, so every car sits parked.
        @(negedge clk);
        status_q = {};
        for (int c = 0; c < 3; c++) begin
          parked = '{car_index: 2'(c), car_floor: 6'd1, door_phase: DOOR_CLOSED,
                     car_mode: 1'b0, car_load: 4'd0, delivered: 4'd0,
                     last_car: (c == 2)};
          status_q = {status_q, parked};
        end
        @(posedge clk);
      end
    end

    random_items(45);
    configure(3, 8, 16, 24, 1, 1, 1);
    random_items(50);
    configure(1, 1, 1, 2, 1, 2, 1);
    random_items(20);
    configure(2, 32, 1, 32, 2, 1, 3);
    random_items(30);
    configure(0, 63, 63, 63, 0, 0, 0);
    random_items(25);
    configure(3, 20, 10, 1, 65535, 65535, 65535);
    random_items(15);
    configure(3, 5, 5, 12, 1, 1, 1);
    random_items(25);
    configure(1, 10, 20, 32, 1, 1, 1);
    random_items(25);
    configure(3, 10, 20, 30, 1, 1, 1);
    random_items(30);

    wait_drained();
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
